// ----- hdl/fixed_block_free_list_allocator_defines.svh -----
// Assertion macros for the fixed block free list allocator.
`ifndef FIXED_BLOCK_FREE_LIST_ALLOCATOR_DEFINES_SVH
`define FIXED_BLOCK_FREE_LIST_ALLOCATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define FBFL_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define FBFL_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define FBFL_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define FBFL_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ----- hdl/fbfl_pkg.sv -----
// Shared widths, operation codes and status codes of the free list allocator.
package fbfl_pkg;

  localparam int FUNC_W = 2;
  localparam int IDX_W  = 8;
  localparam int STAT_W = 2;
  localparam int CNT_W  = 9;

  typedef logic [FUNC_W-1:0] func_t;
  typedef logic [STAT_W-1:0] status_t;

  localparam func_t FUNC_ALLOC = 2'd0;
  localparam func_t FUNC_FREE  = 2'd1;
  localparam func_t FUNC_CLEAR = 2'd2;

  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_EMPTY   = 2'd1;
  localparam status_t ST_RANGE   = 2'd2;
  localparam status_t ST_CLEARED = 2'd3;

  localparam int RESET_COUNT = 256;

endpackage

// ----- hdl/fixed_block_free_list_allocator.sv -----
// Fixed-size block pool allocator: free list kept in a link memory with a head register.
//
// Each accepted request gives exactly one result. An alloc with a block available first reads
// the head entry of the link memory, then in the S_ALLOC state writes the allocated mark back
// and loads the new head; an alloc on an empty pool, a free and the unused code skip that
// second step, since a free writes the link memory without reading it. A clear rewrites every
// one of the MAX_BLOCKS link entries, one per cycle through the single write port, and then
// delivers its result. After reset the same relink pass runs with in_ready low; configuration
// writes are taken throughout. Results are held in an output register, and the next request
// is taken once that register is empty or is being emptied in the same cycle.
module fixed_block_free_list_allocator #(
  parameter int MAX_BLOCKS = 256
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [fbfl_pkg::CNT_W-1:0] cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  fbfl_pkg::func_t           func,
  input  logic [fbfl_pkg::IDX_W-1:0] block_index,
  output logic                      out_valid,
  input  logic                      out_ready,
  output fbfl_pkg::status_t         status,
  output logic [fbfl_pkg::IDX_W-1:0] granted_index
);

  import fbfl_pkg::*;

  `include "fixed_block_free_list_allocator_defines.svh"

  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int LW = $clog2(MAX_BLOCKS + 2);
  localparam int WW = (LW > CNT_W) ? LW : CNT_W;
  localparam int RC = (RESET_COUNT > MAX_BLOCKS) ? MAX_BLOCKS : RESET_COUNT;

  localparam logic [WW-1:0] MAX_W      = WW'(MAX_BLOCKS);
  localparam logic [LW-1:0] END_MARK   = LW'(MAX_BLOCKS);
  localparam logic [LW-1:0] ALLOC_MARK = LW'(MAX_BLOCKS + 1);
  localparam logic [IW-1:0] LAST_IDX   = IW'(MAX_BLOCKS - 1);

  localparam logic [1:0] S_SWEEP = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_ALLOC = 2'd2;

  logic [1:0]         state;
  logic [CNT_W-1:0]   block_count;
  logic [LW-1:0]      head;
  logic [IW-1:0]      sweep_idx;
  logic [WW-1:0]      sweep_cnt;
  logic               sweep_reply;

  logic [WW-1:0]      bc_ext;
  logic [WW-1:0]      eff_count;
  logic [WW-1:0]      idx_ext;
  logic [WW-1:0]      sweep_succ;
  logic               in_acc;
  logic               out_free;
  logic               head_ok;
  logic               in_range;
  logic               sweep_last;

  logic               res_load;
  status_t            res_status;
  logic [IDX_W-1:0]   res_granted;

  logic               mem_we;
  logic [IW-1:0]      mem_waddr;
  logic [LW-1:0]      mem_wdata;
  logic               mem_re;
  logic [LW-1:0]      mem_rdata;

  fbfl_link_ram #(
    .DEPTH(MAX_BLOCKS),
    .WIDTH(LW)
  ) u_link_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(head[IW-1:0]),
    .rdata(mem_rdata)
  );

  assign cfg_ready  = 1'b1;
  assign out_free   = !out_valid || out_ready;
  assign in_ready   = (state == S_IDLE) && out_free;
  assign in_acc     = in_valid && in_ready;
  assign bc_ext     = WW'(block_count);
  assign eff_count  = (bc_ext == '0) ? WW'(1) : ((bc_ext > MAX_W) ? MAX_W : bc_ext);
  assign idx_ext    = WW'(block_index);
  assign head_ok    = WW'(head) < MAX_W;
  assign in_range   = idx_ext < eff_count;
  assign sweep_succ = WW'(sweep_idx) + WW'(1);
  assign sweep_last = sweep_idx == LAST_IDX;
  assign mem_re     = in_acc && (func == FUNC_ALLOC) && head_ok;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = head[IW-1:0];
    mem_wdata = ALLOC_MARK;
    case (state)
      S_SWEEP: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_idx;
        mem_wdata = (sweep_succ < sweep_cnt) ? sweep_succ[LW-1:0] : END_MARK;
      end
      S_ALLOC: begin
        mem_we = 1'b1;
      end
      S_IDLE: begin
        if (in_acc && (func == FUNC_FREE) && in_range) begin
          mem_we    = 1'b1;
          mem_waddr = idx_ext[IW-1:0];
          mem_wdata = head;
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    res_load    = 1'b0;
    res_status  = ST_OK;
    res_granted = '0;
    case (state)
      S_SWEEP: begin
        res_load   = sweep_last && sweep_reply;
        res_status = ST_CLEARED;
      end
      S_ALLOC: begin
        res_load    = 1'b1;
        res_granted = IDX_W'(head);
      end
      S_IDLE: begin
        if (in_acc) begin
          case (func)
            FUNC_ALLOC: begin
              res_load   = !head_ok;
              res_status = ST_EMPTY;
            end
            FUNC_FREE: begin
              res_load   = 1'b1;
              res_status = in_range ? ST_OK : ST_RANGE;
            end
            FUNC_CLEAR: begin
              res_load = 1'b0;
            end
            default: begin
              res_load = 1'b1;
            end
          endcase
        end
      end
      default: begin
        res_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_SWEEP;
      block_count <= CNT_W'(RESET_COUNT);
      head        <= '0;
      sweep_idx   <= '0;
      sweep_cnt   <= WW'(RC);
      sweep_reply <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        block_count <= cfg_data;
      end
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_SWEEP: begin
          sweep_idx <= sweep_idx + IW'(1);
          if (sweep_last) begin
            state <= S_IDLE;
          end
        end
        S_ALLOC: begin
          head  <= mem_rdata;
          state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_acc) begin
            case (func)
              FUNC_ALLOC: begin
                if (head_ok) begin
                  state <= S_ALLOC;
                end
              end
              FUNC_FREE: begin
                if (in_range) begin
                  head <= idx_ext[LW-1:0];
                end
              end
              FUNC_CLEAR: begin
                state       <= S_SWEEP;
                sweep_idx   <= '0;
                sweep_cnt   <= eff_count;
                sweep_reply <= 1'b1;
                head        <= '0;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      status        <= res_status;
      granted_index <= res_granted;
    end
  end

  `FBFL_ASSERT_NXT(a_alloc_reads, clk, rst, mem_re, (state == S_ALLOC) && !out_valid, "alloc did not enter its write-back cycle with the output free")
  `FBFL_ASSERT_NXT(a_alloc_result, clk, rst, state == S_ALLOC, out_valid && (state == S_IDLE), "alloc write-back did not deliver a result")
  `FBFL_ASSERT_IMP(a_sweep_quiet, clk, rst, (state == S_SWEEP) && sweep_reply, !out_valid && !in_ready, "result pending or request taken during a relink pass")

endmodule

// ----- hdl/fbfl_link_ram.sv -----
// Simple dual-port link memory with one write port and one registered read port.
module fbfl_link_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 9
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- tb/fbfl_grant_checker.sv -----
// Checker for the free list allocator: predicts each result from its own copy of the pool and compares.
module fbfl_grant_checker #(
  parameter int MAX_BLOCKS = 256
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [fbfl_pkg::CNT_W-1:0]  cfg_data,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  fbfl_pkg::func_t             func,
  input  logic [fbfl_pkg::IDX_W-1:0]  block_index,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  fbfl_pkg::status_t           status,
  input  logic [fbfl_pkg::IDX_W-1:0]  granted_index,
  output int                          fail_count,
  output int                          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import fbfl_pkg::*;

  localparam logic [CNT_W-1:0] END_LINK   = CNT_W'(MAX_BLOCKS);
  localparam logic [CNT_W-1:0] TAKEN_LINK = CNT_W'(MAX_BLOCKS + 1);

  typedef struct packed {
    status_t           status;
    logic [IDX_W-1:0]  index;
  } grant_t;

  logic [CNT_W-1:0] link_mem [MAX_BLOCKS];
  logic [CNT_W-1:0] head;
  logic [CNT_W-1:0] pool_count;
  grant_t           awaited_grants [$];

  initial begin
    fail_count = 0;
    pending = 0;
  end

  function automatic logic [CNT_W-1:0] usable_blocks();
    if (pool_count == 0) return CNT_W'(1);
    if (pool_count > MAX_BLOCKS) return CNT_W'(MAX_BLOCKS);
    return pool_count;
  endfunction

  function automatic void relink_pool();
    logic [CNT_W-1:0] n;
    n = usable_blocks();
    for (int i = 0; i < MAX_BLOCKS; i++) begin
      if (i + 1 < n) begin
        link_mem[i] = CNT_W'(i + 1);
      end else begin
        link_mem[i] = END_LINK;
      end
    end
    head = '0;
  endfunction

  function automatic grant_t predict_grant(func_t op, logic [IDX_W-1:0] idx);
    grant_t res;
    logic [CNT_W-1:0] h;
    res.status = ST_OK;
    res.index = '0;
    case (op)
      FUNC_ALLOC: begin
        if (head < MAX_BLOCKS) begin
          h = head;
          res.index = h[IDX_W-1:0];
          head = link_mem[h[IDX_W-1:0]];
          link_mem[h[IDX_W-1:0]] = TAKEN_LINK;
        end else begin
          res.status = ST_EMPTY;
        end
      end
      FUNC_FREE: begin
        if ({1'b0, idx} < usable_blocks()) begin
          link_mem[idx] = head;
          head = {1'b0, idx};
        end else begin
          res.status = ST_RANGE;
        end
      end
      FUNC_CLEAR: begin
        relink_pool();
        res.status = ST_CLEARED;
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at %0t ns: %s", $time, what);
    fail_count = fail_count + 1;
  endtask

  always @(posedge clk) begin
    grant_t want;
    if (rst) begin
      pool_count = CNT_W'(RESET_COUNT);
      relink_pool();
      awaited_grants.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        pool_count = cfg_data;
      end
      if (out_valid && out_ready) begin
        if (awaited_grants.size() == 0) begin
          report_mismatch($sformatf("result with nothing awaited: status %0d index %0d",
                                    status, granted_index));
        end else begin
          want = awaited_grants.pop_front();
          if (status !== want.status) begin
            report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
          end
          if (granted_index !== want.index) begin
            report_mismatch($sformatf("granted_index %0d, expected %0d",
                                      granted_index, want.index));
          end
        end
      end
      if (in_valid && in_ready) begin
        awaited_grants.push_back(predict_grant(func, block_index));
      end
    end
    pending <= awaited_grants.size();
  end

endmodule

// ----- tb/tb.sv -----
// Testbench top for the free list allocator: clock, reset, stimulus, back-pressure and verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fbfl_pkg::*;

  localparam int    STALL_LIMIT = 4000;
  localparam func_t FUNC_UNUSED = 2'd3;

  logic               clk;
  logic               rst;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CNT_W-1:0]   cfg_data;
  logic               in_valid;
  logic               in_ready;
  func_t              func;
  logic [IDX_W-1:0]   block_index;
  logic               out_valid;
  logic               out_ready;
  status_t            status;
  logic [IDX_W-1:0]   granted_index;

  int                 fail_count;
  int                 pending;
  int                 idle_cycles;
  bit                 long_hold;
  func_t              sent_ops [$];
  logic [IDX_W-1:0]   held_blocks [$];

  fixed_block_free_list_allocator i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .func          (func),
    .block_index   (block_index),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .granted_index (granted_index)
  );

  fbfl_grant_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .func          (func),
    .block_index   (block_index),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .granted_index (granted_index),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Blocks handed out are collected so that later frees can return them.
  always @(posedge clk) begin
    func_t op;
    if (out_valid && out_ready && sent_ops.size() > 0) begin
      op = sent_ops.pop_front();
      if (status == ST_CLEARED) begin
        held_blocks.delete();
      end else if (op == FUNC_ALLOC && status == ST_OK) begin
        held_blocks.push_back(granted_index);
      end
    end
  end

  initial begin
    int run;
    int gap;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (long_hold) begin
        long_hold = 1'b0;
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
      end
      run = $urandom_range(1, 20);
      gap = $urandom_range(0, 99);
      if (gap < 50) begin
        gap = 0;
      end else if (gap < 90) begin
        gap = $urandom_range(1, 3);
      end else begin
        gap = $urandom_range(15, 50);
      end
      out_ready <= 1'b1;
      repeat (run) @(posedge clk);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  task automatic send_item(func_t op, logic [IDX_W-1:0] idx);
    int r;
    in_valid <= 1'b1;
    func <= op;
    block_index <= idx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_ops.push_back(op);
    r = $urandom_range(0, 99);
    if (r >= 60) begin
      in_valid <= 1'b0;
      repeat (r < 90 ? $urandom_range(1, 3) : $urandom_range(10, 40)) @(posedge clk);
    end
  endtask

  task automatic write_count(logic [CNT_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic random_phase(logic [CNT_W-1:0] count_value, int n_items, bit hold_mid);
    int alloc_weight;
    int r;
    int k;
    alloc_weight = $urandom_range(30, 60);
    write_count(count_value);
    send_item(FUNC_CLEAR, IDX_W'($urandom_range(0, 255)));
    for (int i = 0; i < n_items; i++) begin
      if (hold_mid && i == 30) begin
        long_hold = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < alloc_weight || (r < 88 && held_blocks.size() == 0)) begin
        send_item(FUNC_ALLOC, IDX_W'($urandom_range(0, 255)));
      end else if (r < 88) begin
        k = $urandom_range(0, held_blocks.size() - 1);
        send_item(FUNC_FREE, held_blocks[k]);
        held_blocks.delete(k);
      end else if (r < 93) begin
        send_item(FUNC_FREE, IDX_W'($urandom_range(0, 255)));
      end else if (r < 97) begin
        send_item(FUNC_UNUSED, IDX_W'($urandom_range(0, 255)));
      end else begin
        send_item(FUNC_CLEAR, IDX_W'($urandom_range(0, 255)));
      end
    end
    drain();
  endtask

  initial begin
    logic [CNT_W-1:0] count_value;
    rst = 1'b1;
    idle_cycles = 0;
    long_hold = 1'b0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    func <= FUNC_ALLOC;
    block_index <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Pool as left by reset, all 256 blocks linked in order.
    send_item(FUNC_ALLOC, 8'd0);
    send_item(FUNC_ALLOC, 8'd255);
    send_item(FUNC_FREE, 8'd255);
    send_item(FUNC_ALLOC, 8'd0);
    send_item(FUNC_FREE, 8'd0);
    send_item(FUNC_UNUSED, 8'd255);
    send_item(FUNC_CLEAR, 8'd0);
    drain();

    // A written count of zero leaves a single block.
    write_count(9'd0);
    send_item(FUNC_CLEAR, 8'd255);
    send_item(FUNC_ALLOC, 8'd0);
    send_item(FUNC_ALLOC, 8'd0);
    send_item(FUNC_FREE, 8'd1);
    send_item(FUNC_FREE, 8'd0);
    send_item(FUNC_ALLOC, 8'd0);
    send_item(FUNC_FREE, 8'd255);
    drain();

    // Oversized count: full pool. A double free leads to a double grant and a head on a marker.
    write_count(9'd511);
    send_item(FUNC_CLEAR, 8'd0);
    send_item(FUNC_FREE, 8'd5);
    send_item(FUNC_FREE, 8'd5);
    send_item(FUNC_ALLOC, 8'd0);
    send_item(FUNC_ALLOC, 8'd0);
    send_item(FUNC_ALLOC, 8'd0);
    send_item(FUNC_FREE, 8'd255);
    send_item(FUNC_ALLOC, 8'd0);
    send_item(FUNC_ALLOC, 8'd0);
    drain();

    for (int p = 0; p < 12; p++) begin
      case (p)
        0: count_value = 9'd1;
        1: count_value = 9'd256;
        2: count_value = 9'd2;
        3: count_value = 9'd511;
        4: count_value = 9'd0;
        5: count_value = 9'd255;
        default: begin
          if (p % 2 == 1) begin
            count_value = CNT_W'($urandom_range(3, 40));
          end else begin
            count_value = CNT_W'($urandom_range(1, 511));
          end
        end
      endcase
      random_phase(count_value, $urandom_range(100, 120), p == 1);
    end

    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
